// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/owbm_pkg.sv -----
// Package: types, codes and timing defaults of the 1-Wire bus master.
`timescale 1ns / 1ps
package owbm_pkg;

  localparam int TIMER_WIDTH = 10;
  localparam int REG_WIDTH   = 10;
  localparam int NUM_REGS    = 7;
  localparam int REG_IDX_W   = 3;

  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_RECOV  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_START   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_HOLD    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_RECOV  = 3'd6;

  localparam logic [REG_WIDTH-1:0] RST_RESET_LOW   = 10'd485;
  localparam logic [REG_WIDTH-1:0] RST_PRESENCE    = 10'd65;
  localparam logic [REG_WIDTH-1:0] RST_RESET_RECOV = 10'd500;
  localparam logic [REG_WIDTH-1:0] RST_SLOT_START  = 10'd2;
  localparam logic [REG_WIDTH-1:0] RST_READ_SAMPLE = 10'd4;
  localparam logic [REG_WIDTH-1:0] RST_SLOT_HOLD   = 10'd62;
  localparam logic [REG_WIDTH-1:0] RST_WRITE_RECOV = 10'd2;

  // One classified tick as held in the queue.
  typedef struct packed {
    logic       line;
    logic       start;
    logic [1:0] cmd;
    logic [7:0] wdata;
  } tick_t;

  // One tick's outcome.
  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       present;
  } result_t;

endpackage

// ----- hw/rtl/owbm_front.sv -----
// Front end: decodes incoming ticks and queues them for the sequencer.
`timescale 1ns / 1ps
module owbm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           line_level,
  input  logic           cmd_valid,
  input  logic [1:0]     mode,
  input  logic [7:0]     write_data,
  output logic           q_valid,
  input  logic           q_pop,
  output owbm_pkg::tick_t q_item
);
  import owbm_pkg::*;

  tick_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  tick_t      item;

  always_comb begin
    item.line  = line_level;
    item.start = cmd_valid && (mode != CMD_NONE);
    item.cmd   = mode;
    item.wdata = write_data;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/owbm_seq.sv -----
// Back end: slot sequencer, timing registers and result register.
`timescale 1ns / 1ps
module owbm_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [owbm_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [owbm_pkg::REG_WIDTH-1:0]     cfg_data,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  owbm_pkg::tick_t                    q_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output owbm_pkg::result_t                  out_res
);
  import owbm_pkg::*;

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_RST_LOW     = 3'd1;
  localparam logic [2:0] PH_RST_WAIT    = 3'd2;
  localparam logic [2:0] PH_RST_RECOV   = 3'd3;
  localparam logic [2:0] PH_SLOT_START  = 3'd4;
  localparam logic [2:0] PH_READ_WAIT   = 3'd5;
  localparam logic [2:0] PH_SLOT_HOLD   = 3'd6;
  localparam logic [2:0] PH_WRITE_RECOV = 3'd7;

  logic [REG_WIDTH-1:0] tm_reset_low, tm_presence, tm_reset_recov, tm_slot_start;
  logic [REG_WIDTH-1:0] tm_read_sample, tm_slot_hold, tm_write_recov;

  logic [2:0]             phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_next;
  logic [2:0]             bit_index, bit_next;
  logic [7:0]             shift_byte, shift_next;
  logic [1:0]             cur_cmd, cmd_next;
  logic                   presence, presence_next;
  logic [7:0]             last_read, last_read_next;

  logic                   start;
  logic [2:0]             ph;
  logic [TIMER_WIDTH-1:0] tick;
  logic [TIMER_WIDTH:0]   tick_sum;
  logic [REG_WIDTH-1:0]   len_reg;
  logic [TIMER_WIDTH-1:0] len_masked;
  logic [TIMER_WIDTH:0]   len;
  logic                   expire;
  logic                   last_bit;
  logic                   drive, busy, done;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tm_reset_low   <= RST_RESET_LOW;
      tm_presence    <= RST_PRESENCE;
      tm_reset_recov <= RST_RESET_RECOV;
      tm_slot_start  <= RST_SLOT_START;
      tm_read_sample <= RST_READ_SAMPLE;
      tm_slot_hold   <= RST_SLOT_HOLD;
      tm_write_recov <= RST_WRITE_RECOV;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:   tm_reset_low   <= cfg_data;
        REG_PRESENCE:    tm_presence    <= cfg_data;
        REG_RESET_RECOV: tm_reset_recov <= cfg_data;
        REG_SLOT_START:  tm_slot_start  <= cfg_data;
        REG_READ_SAMPLE: tm_read_sample <= cfg_data;
        REG_SLOT_HOLD:   tm_slot_hold   <= cfg_data;
        REG_WRITE_RECOV: tm_write_recov <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    start    = (phase == PH_IDLE) && q_item.start;
    ph       = phase;
    cmd_next = cur_cmd;
    shift_next = shift_byte;
    bit_next = bit_index;
    tick     = tick_count;
    if (start) begin
      ph         = (q_item.cmd == CMD_RESET) ? PH_RST_LOW : PH_SLOT_START;
      cmd_next   = q_item.cmd;
      shift_next = (q_item.cmd == CMD_WRITE) ? q_item.wdata : 8'd0;
      bit_next   = 3'd0;
      tick       = '0;
    end

    case (ph)
      PH_RST_LOW:    len_reg = tm_reset_low;
      PH_RST_WAIT:   len_reg = tm_presence;
      PH_RST_RECOV:  len_reg = tm_reset_recov;
      PH_SLOT_START: len_reg = tm_slot_start;
      PH_READ_WAIT:  len_reg = tm_read_sample;
      PH_SLOT_HOLD:  len_reg = tm_slot_hold;
      default:       len_reg = tm_write_recov;
    endcase
    len_masked = TIMER_WIDTH'(len_reg);
    len        = (len_masked == '0) ? (TIMER_WIDTH+1)'(1) : {1'b0, len_masked};
    tick_sum   = {1'b0, tick} + (TIMER_WIDTH+1)'(1);
    expire     = (tick_sum >= len);
    last_bit   = (bit_next == 3'd7);

    busy  = (ph != PH_IDLE);
    drive = (ph == PH_RST_LOW) || (ph == PH_SLOT_START) ||
            ((ph == PH_SLOT_HOLD) && (cmd_next == CMD_WRITE) && !shift_next[0]);
    done  = 1'b0;

    phase_next     = ph;
    tick_next      = busy ? tick_sum[TIMER_WIDTH-1:0] : tick;
    presence_next  = presence;
    last_read_next = last_read;

    if (busy && expire) begin
      tick_next = '0;
      case (ph)
        PH_RST_LOW: phase_next = PH_RST_WAIT;
        PH_RST_WAIT: begin
          presence_next = !q_item.line;
          phase_next    = PH_RST_RECOV;
        end
        PH_RST_RECOV: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        PH_SLOT_START: begin
          phase_next = (cmd_next == CMD_WRITE) ? PH_SLOT_HOLD : PH_READ_WAIT;
        end
        PH_READ_WAIT: begin
          shift_next = {q_item.line, shift_next[7:1]};
          phase_next = PH_SLOT_HOLD;
        end
        PH_SLOT_HOLD: begin
          if (cmd_next == CMD_WRITE) begin
            shift_next = {1'b0, shift_next[7:1]};
            phase_next = PH_WRITE_RECOV;
          end else if (last_bit) begin
            if (cmd_next == CMD_READ) begin
              last_read_next = shift_next;
            end
            bit_next   = 3'd0;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_next   = bit_next + 3'd1;
            phase_next = PH_SLOT_START;
          end
        end
        default: begin
          if (last_bit) begin
            if (cmd_next == CMD_READ) begin
              last_read_next = shift_next;
            end
            bit_next   = 3'd0;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_next   = bit_next + 3'd1;
            phase_next = PH_SLOT_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= 3'd0;
      shift_byte <= 8'd0;
      cur_cmd    <= CMD_RESET;
      presence   <= 1'b0;
      last_read  <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase      <= phase_next;
        tick_count <= tick_next;
        bit_index  <= bit_next;
        shift_byte <= shift_next;
        cur_cmd    <= cmd_next;
        presence   <= presence_next;
        last_read  <= last_read_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res.drive   <= drive;
      out_res.busy    <= busy;
      out_res.done    <= done;
      out_res.rdata   <= last_read_next;
      out_res.present <= presence_next;
    end
  end

endmodule

// ----- hw/rtl/onewire_bus_master_unit.sv -----
// Top level: 1-Wire bus master, one transfer in and one transfer out per bus tick.
// Each input transfer is one microsecond tick of bus time and yields exactly one
// output transfer that carries the line drive, busy and done flags, the last byte
// read and the presence flag. One transfer per cycle is sustained while the output
// is not stalled; each tick passes through the two-entry input queue and then the
// output register. The input side keeps taking transfers while the output is stalled
// until the queue holds two ticks. Timing registers take effect on the next tick
// after a write.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module onewire_bus_master_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // line_level[0], cmd_valid[1], mode[3:2], write_data[11:4], zero[15:12]
  input  logic [15:0]                        s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // drive_low[0], busy_res[1], done_res[2], read_data[10:3], device_present[11],
  // zero[15:12]
  output logic [15:0]                        m_tdata,
  input  logic                               cfg_we,
  input  logic [owbm_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [owbm_pkg::REG_WIDTH-1:0]     cfg_data
);
  import owbm_pkg::*;

  logic    q_valid;
  logic    q_pop;
  tick_t   q_item;
  result_t res;

  owbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .line_level (s_tdata[0]),
    .cmd_valid  (s_tdata[1]),
    .mode       (s_tdata[3:2]),
    .write_data (s_tdata[11:4]),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  owbm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {4'b0000, res.present, res.rdata, res.done, res.busy, res.drive};

  `ASSERT_IMPL(a_done_busy, clk, rst, m_tvalid && m_tdata[2], m_tdata[1], "done without busy")
  `ASSERT_IMPL(a_drive_busy, clk, rst, m_tvalid && m_tdata[0], m_tdata[1], "drive while idle")
  `ASSERT_IMPL(a_full_stall, clk, rst, !s_tready, $past(m_tvalid && !m_tready), "queue full without output stall")
  `ASSERT_CLK(a_pop_room, clk, rst, !q_pop || q_valid, "pop from empty queue")

endmodule

// ----- tb/tb_onewire_bus_master_unit.sv -----
// Self-checking testbench for the 1-Wire bus master: per-tick prediction and stream checks.
`timescale 1ns / 1ps
module tb_onewire_bus_master_unit;
  import owbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_RECOV,
    PH_SLOT_START, PH_READ_WAIT, PH_SLOT_HOLD, PH_WRITE_RECOV
  } bus_phase_e;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [REG_IDX_W-1:0] REG_ORDER[NUM_REGS] = '{
    REG_RESET_LOW, REG_PRESENCE, REG_RESET_RECOV, REG_SLOT_START,
    REG_READ_SAMPLE, REG_SLOT_HOLD, REG_WRITE_RECOV
  };
  localparam int LINE_LOW  = 0;
  localparam int LINE_HIGH = 1;
  localparam int LINE_RAND = 2;

  class owbm_tick_board;
    logic [REG_WIDTH-1:0] timing[NUM_REGS];
    bus_phase_e ph;
    int         tick_cnt;
    int         bit_idx;
    logic [7:0] shreg;
    logic [1:0] cur_cmd;
    logic       present;
    logic [7:0] last_rd;
    result_t    bus_outcomes[$];
    int         errors;

    function new();
      timing = '{RST_RESET_LOW, RST_PRESENCE, RST_RESET_RECOV, RST_SLOT_START,
                 RST_READ_SAMPLE, RST_SLOT_HOLD, RST_WRITE_RECOV};
      ph       = PH_IDLE;
      tick_cnt = 0;
      bit_idx  = 0;
      shreg    = '0;
      cur_cmd  = CMD_RESET;
      present  = 1'b0;
      last_rd  = '0;
      errors   = 0;
    endfunction

    function void set_timing(logic [REG_IDX_W-1:0] idx, logic [REG_WIDTH-1:0] v);
      if (idx < NUM_REGS) timing[idx] = v;
    endfunction

    function bit cmd_idle();
      return ph == PH_IDLE;
    endfunction

    function int pending();
      return bus_outcomes.size();
    endfunction

    function int span(bus_phase_e p);
      logic [TIMER_WIDTH-1:0] d;
      case (p)
        PH_RST_LOW:    d = timing[REG_RESET_LOW];
        PH_RST_WAIT:   d = timing[REG_PRESENCE];
        PH_RST_RECOV:  d = timing[REG_RESET_RECOV];
        PH_SLOT_START: d = timing[REG_SLOT_START];
        PH_READ_WAIT:  d = timing[REG_READ_SAMPLE];
        PH_SLOT_HOLD:  d = timing[REG_SLOT_HOLD];
        default:       d = timing[REG_WRITE_RECOV];
      endcase
      return (d == 0) ? 1 : int'(d);
    endfunction

    // closes one bit slot, true once all eight bits are through
    function bit end_of_bit();
      if (bit_idx >= 7) begin
        if (cur_cmd == CMD_READ) last_rd = shreg;
        bit_idx = 0;
        ph = PH_IDLE;
        return 1'b1;
      end
      bit_idx++;
      ph = PH_SLOT_START;
      return 1'b0;
    endfunction

    function void take_tick(tick_t t);
      result_t r;
      r = '0;
      if (ph == PH_IDLE && t.start && t.cmd != CMD_NONE) begin
        cur_cmd  = t.cmd;
        bit_idx  = 0;
        tick_cnt = 0;
        shreg    = (t.cmd == CMD_WRITE) ? t.wdata : 8'h00;
        ph       = (t.cmd == CMD_RESET) ? PH_RST_LOW : PH_SLOT_START;
      end
      if (ph != PH_IDLE) begin
        r.busy = 1'b1;
        if (ph == PH_RST_LOW || ph == PH_SLOT_START) r.drive = 1'b1;
        else if (ph == PH_SLOT_HOLD && cur_cmd == CMD_WRITE) r.drive = ~shreg[0];
        tick_cnt++;
        if (tick_cnt >= span(ph)) begin
          tick_cnt = 0;
          case (ph)
            PH_RST_LOW:  ph = PH_RST_WAIT;
            PH_RST_WAIT: begin
              present = ~t.line;
              ph = PH_RST_RECOV;
            end
            PH_RST_RECOV: begin
              ph = PH_IDLE;
              r.done = 1'b1;
            end
            PH_SLOT_START: ph = (cur_cmd == CMD_WRITE) ? PH_SLOT_HOLD : PH_READ_WAIT;
            PH_READ_WAIT: begin
              shreg = {t.line, shreg[7:1]};
              ph = PH_SLOT_HOLD;
            end
            PH_SLOT_HOLD: begin
              if (cur_cmd == CMD_WRITE) begin
                shreg = shreg >> 1;
                ph = PH_WRITE_RECOV;
              end else begin
                r.done = end_of_bit();
              end
            end
            default: r.done = end_of_bit();
          endcase
        end
      end
      r.rdata   = last_rd;
      r.present = present;
      bus_outcomes.push_back(r);
    endfunction

    function void match_result(logic [15:0] d);
      result_t got, want;
      got.drive   = d[0];
      got.busy    = d[1];
      got.done    = d[2];
      got.rdata   = d[10:3];
      got.present = d[11];
      if (bus_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer out: %h", d);
        return;
      end
      want = bus_outcomes.pop_front();
      if (got.drive !== want.drive || got.busy !== want.busy || got.done !== want.done ||
          got.rdata !== want.rdata || got.present !== want.present) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp drive %b busy %b done %b rdata %h pres %b, got %b %b %b %h %b",
                   want.drive, want.busy, want.done, want.rdata, want.present,
                   got.drive, got.busy, got.done, got.rdata, got.present);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_WIDTH-1:0] cfg_data = '0;

  owbm_tick_board sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  onewire_bus_master_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      m_tready <= 1'b0;
      hold_left <= 60;
      hold_seen <= hold_asked;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_result(m_tdata);
  end

  function automatic logic [1:0] pick_cmd();
    int m;
    m = $urandom_range(0, 9);
    if (m < 3) return CMD_RESET;
    if (m < 6) return CMD_WRITE;
    if (m < 9) return CMD_READ;
    return CMD_NONE;
  endfunction

  task automatic send_tick(input logic line, input logic start, input logic [1:0] cmd,
                           input logic [7:0] wdata);
    tick_t t;
    t.line  = line;
    t.start = start;
    t.cmd   = cmd;
    t.wdata = wdata;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, wdata, cmd, start, line};
    do @(posedge clk); while (!s_tready);
    sb.take_tick(t);
  endtask

  // one command, then ticks of noise until the command has finished
  task automatic run_cmd(input logic [1:0] cmd, input logic [7:0] wdata, input int line_sel);
    logic ln;
    int   n;
    n = 0;
    do begin
      ln = (line_sel == LINE_RAND) ? 1'($urandom_range(0, 1)) : (line_sel == LINE_HIGH);
      if (n == 0) send_tick(ln, 1'b1, cmd, wdata);
      else send_tick(ln, 1'($urandom_range(0, 1)), pick_cmd(), 8'($urandom));
      n++;
    end while (!sb.cmd_idle());
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input logic [REG_WIDTH-1:0] v[NUM_REGS], input bit stray);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= v[i];
      sb.set_timing(REG_ORDER[i], v[i]);
      @(posedge clk);
    end
    if (stray) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_data  <= REG_WIDTH'($urandom);
      sb.set_timing(REG_UNUSED, cfg_data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [REG_WIDTH-1:0] v[NUM_REGS];
    int idle_set[4];
    int stall_set[4];
    sb = new();
    idle_set  = '{0, 75, 0, 27};
    stall_set = '{0, 0, 75, 27};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ticks that start nothing
    send_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
    send_tick(1'b1, 1'b0, CMD_READ, 8'hFF);
    run_cmd(CMD_NONE, 8'h5A, LINE_RAND);
    settle();

    // shortest timings
    v = '{default: 10'd1};
    load_timing(v, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, LINE_RAND);
    run_cmd(CMD_WRITE, 8'hFF, LINE_RAND);
    run_cmd(CMD_READ, 8'h00, LINE_LOW);
    run_cmd(CMD_READ, 8'h00, LINE_HIGH);
    run_cmd(CMD_RESET, 8'h00, LINE_HIGH);
    run_cmd(CMD_RESET, 8'h00, LINE_LOW);
    run_cmd(CMD_NONE, 8'hFF, LINE_RAND);
    settle();

    // zero counts last one tick; also a write to an unmapped index
    v = '{default: 10'd0};
    load_timing(v, 1'b1);
    run_cmd(CMD_WRITE, 8'($urandom), LINE_RAND);
    run_cmd(CMD_READ, 8'h00, LINE_RAND);
    run_cmd(CMD_RESET, 8'h00, LINE_RAND);
    settle();

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < NUM_REGS; i++)
        v[i] = ($urandom_range(0, 7) == 0) ? REG_WIDTH'($urandom_range(6, 12))
                                            : REG_WIDTH'($urandom_range(1, 5));
      load_timing(v, p == 0);
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int k = 0; k < 220; k++) begin
        if (p == 0 && k == 100) hold_asked <= hold_asked + 1;
        if (p == 3 && k == 150) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 40, pick_cmd(),
                  8'($urandom));
      end
      while (!sb.cmd_idle())
        send_tick(1'($urandom_range(0, 1)), 1'b0, pick_cmd(), 8'($urandom));
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- onewire_bus_master_unit.f -----
+incdir+hw/rtl
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_front.sv
hw/rtl/owbm_seq.sv
hw/rtl/onewire_bus_master_unit.sv
tb/tb_onewire_bus_master_unit.sv
